/* rtl/core/sgb_pkg.sv */
// Package for the segment gap bridger: sizes, codes, request and result types.
// No dependencies; compile first.
`default_nettype none

package sgb_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int COORD_BITS   = 12;

    localparam int SLOT_W     = 5;
    localparam int ADDR_W     = $clog2(MAX_SEGMENTS);
    localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int LIMIT_W    = 26;
    localparam int SEGS_W     = 6;
    localparam int CFG_DATA_W = 26;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int CSQ_W    = 2 * MAG_W;
    localparam int LEN2_W   = PROD_W;
    localparam int LIMLEN_W = LIMIT_W + LEN2_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1440);
    localparam logic [SEGS_W-1:0]  SEGS_RESET  = SEGS_W'(32);

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_kind;

    typedef enum logic [0:0] {
        CFG_LIMIT = 1'b0,
        CFG_SEGS  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REF,
        ST_LEN,
        ST_LIM,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        t_req_kind               req_type;
        logic [SLOT_W-1:0]       slot;
        logic [COORD_BITS-1:0]   x_start;
        logic [COORD_BITS-1:0]   y_start;
        logic [COORD_BITS-1:0]   x_end;
        logic [COORD_BITS-1:0]   y_end;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_W-1:0]       partner;
        logic [COORD_BITS-1:0]   bridge_from_x;
        logic [COORD_BITS-1:0]   bridge_from_y;
        logic [COORD_BITS-1:0]   bridge_to_x;
        logic [COORD_BITS-1:0]   bridge_to_y;
        logic                    last;
    } t_res;

    typedef struct packed {
        logic [COORD_BITS-1:0]   xs;
        logic [COORD_BITS-1:0]   ys;
        logic [COORD_BITS-1:0]   xe;
        logic [COORD_BITS-1:0]   ye;
    } t_seg;

endpackage

`default_nettype wire

/* rtl/core/sgb_req_if.sv */
// Request channel: valid/ready handshake carrying one load or query request.
// Depends on sgb_pkg.
`default_nettype none

interface sgb_req_if;
    import sgb_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/sgb_res_if.sv */
// Result channel: valid/ready handshake carrying one per-slot result.
// Depends on sgb_pkg.
`default_nettype none

interface sgb_res_if;
    import sgb_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/segment_gap_bridger_top.sv */
// Segment gap bridger top level: segment table memory, query sequencer, compare pipeline.
// Depends on sgb_pkg, sgb_req_if, sgb_res_if.
//
// Usage:
//   i_req carries load and query requests. A load writes one segment into a
//   table slot; the block is ready again the next cycle. A query names a
//   reference slot. The block reads the reference, passes through the setup
//   states REF, LEN and LIM (deltas, squared length, limit times squared
//   length), then reads one table slot per cycle while o_res is not stalled,
//   0 up to segments_in_use-1 (capped at 32), feeding a four-stage compare
//   pipeline that ends in the output register of o_res. Results follow one
//   per cycle while o_res does not stall. A query holds the request channel
//   until its last slot has left stage D; the segment table has a single read
//   port. When o_res stalls, the whole compare pipeline and the table read
//   hold in place; nothing is dropped and the walk resumes when the stall
//   clears. Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) must be written
//   only while idle; the block does not enforce this. Reset clears the
//   sequencer, the pipeline valid bits and the registers to their defaults
//   (limit 1440, 32 slots). The table itself is not cleared.
`default_nettype none

module segment_gap_bridger_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    sgb_req_if.sink                          i_req,
    sgb_res_if.source                        o_res,
    input  wire                              i_cfg_we,
    input  sgb_pkg::t_cfg_idx                i_cfg_idx,
    input  wire [sgb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sgb_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] r_limit;
    logic [SEGS_W-1:0]  r_seg_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_seg_use <= SEGS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT: r_limit   <= LIMIT_W'(i_cfg_data);
                CFG_SEGS:  r_seg_use <= SEGS_W'(i_cfg_data);
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Segment table: one write port, one registered read port
    // ------------------------------------------------------------------
    t_seg              mem [MAX_SEGMENTS];
    t_seg              r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= '{xs: i_req.payload.x_start, ys: i_req.payload.y_start,
                              xe: i_req.payload.x_end,   ye: i_req.payload.y_end};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_j, r_walk;
    logic [CNT_W-1:0]  walk_sat;
    logic              slot_ok;
    logic              advance;
    logic              issue;
    logic              issue_last;
    logic              r_va, r_vb, r_vc, r_vd;
    logic              r_out_valid;

    assign slot_ok    = int'(i_req.payload.slot) < MAX_SEGMENTS;
    assign advance    = !r_out_valid || o_res.ready;
    assign issue_last = (r_j + CNT_W'(1)) == r_walk;
    assign wr_addr    = ADDR_W'(i_req.payload.slot);

    always_comb begin
        if (int'(r_seg_use) > MAX_SEGMENTS) begin
            walk_sat = CNT_W'(MAX_SEGMENTS);
        end else begin
            walk_sat = CNT_W'(r_seg_use);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = ADDR_W'(i_req.payload.slot);
        issue       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Ready is held high here, so a valid request is taken this cycle.
                i_req.ready = 1'b1;
                if (i_req.valid && slot_ok) begin
                    if (i_req.payload.req_type == REQ_LOAD) begin
                        mem_we = 1'b1;
                    end else if (walk_sat != '0) begin
                        // Fetch the reference segment.
                        rd_en   = 1'b1;
                        n_state = ST_REF;
                    end
                end
            end
            ST_REF:  n_state = ST_LEN;
            ST_LEN:  n_state = ST_LIM;
            ST_LIM:  n_state = ST_WALK;
            ST_WALK: begin
                rd_addr = ADDR_W'(r_j);
                if (advance) begin
                    rd_en = 1'b1;
                    issue = 1'b1;
                    if (issue_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!(r_va || r_vb || r_vc || r_vd)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Walk counter and walk length, latched per query.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j    <= '0;
            r_walk <= '0;
        end else if (r_state == ST_IDLE) begin
            r_j    <= '0;
            r_walk <= walk_sat;
        end else if (issue) begin
            r_j <= r_j + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Query setup: reference, deltas, squared length, scaled limit
    // ------------------------------------------------------------------
    t_seg                      r_ref;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic [LEN2_W-1:0]         r_len2;
    logic [LIMLEN_W-1:0]       r_limlen;
    logic                      r_len_zero;
    logic signed [PROD_W-1:0]  sq_dx, sq_dy;

    assign sq_dx = r_dx * r_dx;
    assign sq_dy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_REF) begin
            r_ref <= r_rd_data;
            r_dx  <= $signed({1'b0, r_rd_data.xe}) - $signed({1'b0, r_rd_data.xs});
            r_dy  <= $signed({1'b0, r_rd_data.ye}) - $signed({1'b0, r_rd_data.ys});
        end
        if (r_state == ST_LEN) begin
            r_len2 <= LEN2_W'($unsigned(sq_dx)) + LEN2_W'($unsigned(sq_dy));
        end
        if (r_state == ST_LIM) begin
            // Compare cross^2 against limit * |d|^2: no division needed.
            r_limlen   <= LIMLEN_W'(r_limit) * LIMLEN_W'(r_len2);
            r_len_zero <= (r_len2 == '0);
        end
    end

    // ------------------------------------------------------------------
    // Compare pipeline: A (table read) -> B (products) -> C (cross, pick)
    //                   -> D (squares) -> output register
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] r_ja, r_jb, r_jc, r_jd;
    logic              r_la, r_lb, r_lc, r_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_vd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_va        <= issue;
            r_vb        <= r_va;
            r_vc        <= r_vb;
            r_vd        <= r_vc;
            r_out_valid <= r_vd;
        end
    end

    // Stage B: four cross-product terms against the reference line.
    logic signed [DIFF_W-1:0] ay1, ax1, ay2, ax2;
    logic signed [PROD_W-1:0] r_p1a, r_p1b, r_p2a, r_p2b;
    t_seg                     r_seg_b;

    assign ay1 = $signed({1'b0, r_rd_data.ys}) - $signed({1'b0, r_ref.ys});
    assign ax1 = $signed({1'b0, r_rd_data.xs}) - $signed({1'b0, r_ref.xs});
    assign ay2 = $signed({1'b0, r_rd_data.ye}) - $signed({1'b0, r_ref.ys});
    assign ax2 = $signed({1'b0, r_rd_data.xe}) - $signed({1'b0, r_ref.xs});

    // Stage C: cross magnitudes, pick nearer endpoint (tie keeps first).
    logic signed [CROSS_W-1:0] c1, c2;
    logic [MAG_W-1:0]          m1, m2;
    logic [MAG_W-1:0]          r_cmag;
    logic [COORD_BITS-1:0]     r_cx, r_cy;

    assign c1 = r_p1a - r_p1b;
    assign c2 = r_p2a - r_p2b;
    assign m1 = c1[CROSS_W-1] ? MAG_W'(-c1) : MAG_W'(c1);
    assign m2 = c2[CROSS_W-1] ? MAG_W'(-c2) : MAG_W'(c2);

    // Stage D: squared cross and squared gap to the reference end point.
    logic signed [DIFF_W-1:0] gx, gy;
    logic signed [PROD_W-1:0] sq_gx, sq_gy;
    logic [CSQ_W-1:0]         r_csq;
    logic [LEN2_W-1:0]        r_gap;
    logic [COORD_BITS-1:0]    r_cxd, r_cyd;

    assign gx    = $signed({1'b0, r_ref.xe}) - $signed({1'b0, r_cx});
    assign gy    = $signed({1'b0, r_ref.ye}) - $signed({1'b0, r_cy});
    assign sq_gx = gx * gx;
    assign sq_gy = gy * gy;

    // Output stage: zero-length check and both tests, miss clears the bridge fields.
    logic hit;
    t_res r_out;

    assign hit = !r_len_zero && (r_csq < r_limlen) && (r_gap < LEN2_W'(r_limit));

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ja    <= ADDR_W'(r_j);
            r_la    <= issue_last;

            r_jb    <= r_ja;
            r_lb    <= r_la;
            r_seg_b <= r_rd_data;
            r_p1a   <= r_dx * ay1;
            r_p1b   <= r_dy * ax1;
            r_p2a   <= r_dx * ay2;
            r_p2b   <= r_dy * ax2;

            r_jc    <= r_jb;
            r_lc    <= r_lb;
            if (m1 > m2) begin
                r_cmag <= m2;
                r_cx   <= r_seg_b.xe;
                r_cy   <= r_seg_b.ye;
            end else begin
                r_cmag <= m1;
                r_cx   <= r_seg_b.xs;
                r_cy   <= r_seg_b.ys;
            end

            r_jd    <= r_jc;
            r_ld    <= r_lc;
            r_cxd   <= r_cx;
            r_cyd   <= r_cy;
            r_csq   <= CSQ_W'(r_cmag) * CSQ_W'(r_cmag);
            r_gap   <= LEN2_W'($unsigned(sq_gx)) + LEN2_W'($unsigned(sq_gy));

            r_out.hit           <= hit;
            r_out.partner       <= SLOT_W'(r_jd);
            r_out.bridge_from_x <= hit ? r_ref.xe : '0;
            r_out.bridge_from_y <= hit ? r_ref.ye : '0;
            r_out.bridge_to_x   <= hit ? r_cxd    : '0;
            r_out.bridge_to_y   <= hit ? r_cyd    : '0;
            r_out.last          <= r_ld;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for segment_gap_bridger_top: drives load and query requests,
// predicts every per-slot result in-bench and compares each one as it leaves the block.
// Depends on sgb_pkg, sgb_req_if, sgb_res_if and segment_gap_bridger_top.

module testbench;
    import sgb_pkg::*;

    // Allow for the longest quiet stretch: query setup, receiver stalls, sender gaps.
    localparam int WATCHDOG_CYCLES = 2000;
    // Cycles to let a trailing load settle before touching the registers.
    localparam int SETTLE_CYCLES   = 16;
    localparam int MAX_REPORTS     = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sgb_req_if req_bus ();
    sgb_res_if res_bus ();

    segment_gap_bridger_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Requests waiting for the driver; front entry is the one on the bus.
    t_req pending_reqs[$];
    // Per-slot results predicted for accepted queries, oldest first.
    t_res expected_results[$];

    // Shadow copy of the segment table and of the two registers.
    t_seg              seg_shadow [MAX_SEGMENTS];
    logic [LIMIT_W-1:0] limit_shadow;
    logic [SEGS_W-1:0]  walk_shadow;

    // Generator side: which slots will have been loaded once the queue drains,
    // and how many slots the current setting walks.
    logic [31:0] gen_loaded;
    int          gen_walk;
    // Shared line that most generated segments lie along, re-rolled per phase.
    int          line_ox, line_oy, line_ux, line_uy;

    bit          idle_on;
    int          burst_left;
    int          gap_left;
    logic [31:0] stall_pattern;
    int          stall_phase;
    int          quiet_cycles;
    int          mismatches;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Apply one accepted request: store a load, or expand a query into one
    // result per walked slot.
    task automatic predict_request(input t_req r);
        t_seg                  ref_seg;
        t_seg                  cand;
        longint                sx, sy, ex, ey, dx, dy, len2, limit_val;
        longint                px, py, qx, qy, c1, c2, best, gx, gy, gap;
        logic [COORD_BITS-1:0] near_x, near_y;
        int                    n, j;
        bit                    hit;
        t_res                  res;
        if (r.req_type == REQ_LOAD) begin
            seg_shadow[r.slot] = {r.x_start, r.y_start, r.x_end, r.y_end};
            return;
        end
        // Walk length saturates at the table size; zero walks nothing.
        n = (walk_shadow > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(walk_shadow);
        ref_seg = seg_shadow[r.slot];
        sx = ref_seg.xs;
        sy = ref_seg.ys;
        ex = ref_seg.xe;
        ey = ref_seg.ye;
        dx = ex - sx;
        dy = ey - sy;
        len2 = dx * dx + dy * dy;
        limit_val = limit_shadow;
        for (j = 0; j < n; j++) begin
            cand = seg_shadow[j];
            px = cand.xs;
            py = cand.ys;
            qx = cand.xe;
            qy = cand.ye;
            c1 = dx * (py - sy) - dy * (px - sx);
            c2 = dx * (qy - sy) - dy * (qx - sx);
            c1 = (c1 < 0) ? -c1 : c1;
            c2 = (c2 < 0) ? -c2 : c2;
            // Nearer endpoint to the reference line; a tie keeps the first one.
            if (c1 > c2) begin
                best = c2;
                near_x = cand.xe;
                near_y = cand.ye;
            end else begin
                best = c1;
                near_x = cand.xs;
                near_y = cand.ys;
            end
            gx = ex - longint'(near_x);
            gy = ey - longint'(near_y);
            gap = gx * gx + gy * gy;
            // A zero-length reference has no line, so it never hits.
            hit = (len2 != 0) && (best * best < limit_val * len2) && (gap < limit_val);
            res.hit           = hit;
            res.partner       = SLOT_W'(j);
            res.bridge_from_x = hit ? ref_seg.xe : '0;
            res.bridge_from_y = hit ? ref_seg.ye : '0;
            res.bridge_to_x   = hit ? near_x : '0;
            res.bridge_to_y   = hit ? near_y : '0;
            res.last          = (j == n - 1);
            expected_results.insert(expected_results.size(), res);
        end
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            if (mismatches < MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_load(input logic [SLOT_W-1:0] slot,
                              input logic [COORD_BITS-1:0] xs, ys, xe, ye);
        t_req r;
        r.req_type = REQ_LOAD;
        r.slot     = slot;
        r.x_start  = xs;
        r.y_start  = ys;
        r.x_end    = xe;
        r.y_end    = ye;
        pending_reqs.insert(pending_reqs.size(), r);
        gen_loaded[slot] = 1'b1;
    endtask

    // Coordinates of a query are don't-care; fill them with noise.
    task automatic queue_query(input logic [SLOT_W-1:0] slot);
        t_req r;
        r.req_type = REQ_QUERY;
        r.slot     = slot;
        r.x_start  = COORD_BITS'($urandom);
        r.y_start  = COORD_BITS'($urandom);
        r.x_end    = COORD_BITS'($urandom);
        r.y_end    = COORD_BITS'($urandom);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return COORD_BITS'(v);
    endfunction

    // Point near parameter t of the phase's shared line, jittered by a few pixels.
    function automatic logic [COORD_BITS-1:0] line_coord(input int origin, input int step,
                                                         input int t);
        return clamp_coord(origin + step * t + int'($urandom_range(0, 6)) - 3);
    endfunction

    // One random request. Queries only go out once every walked slot holds a
    // segment, so no unwritten entry is ever read.
    task automatic add_random_request();
        logic [31:0]           need;
        logic [SLOT_W-1:0]     slot;
        logic [COORD_BITS-1:0] xs, ys, xe, ye;
        int                    t0, t1, kind;
        need = (gen_walk >= 32) ? '1 : ((32'd1 << gen_walk) - 1);
        if ((gen_loaded & need) == need && $urandom_range(0, 99) < 45) begin
            do
                slot = SLOT_W'($urandom);
            while (!gen_loaded[slot]);
            queue_query(slot);
            return;
        end
        if ((gen_loaded & need) != need) begin
            slot = '0;
            while (gen_loaded[slot])
                slot++;
        end else begin
            slot = SLOT_W'($urandom);
        end
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            // Nearly collinear piece of the shared line, either direction.
            t0 = $urandom_range(0, 60);
            t1 = t0 + int'($urandom_range(1, 10));
            if ($urandom_range(0, 1)) begin
                t0 = t0 ^ t1;
                t1 = t0 ^ t1;
                t0 = t0 ^ t1;
            end
            xs = line_coord(line_ox, line_ux, t0);
            ys = line_coord(line_oy, line_uy, t0);
            xe = line_coord(line_ox, line_ux, t1);
            ye = line_coord(line_oy, line_uy, t1);
        end else if (kind < 66) begin
            // Degenerate segment: both endpoints the same.
            xs = COORD_BITS'($urandom);
            ys = COORD_BITS'($urandom);
            xe = xs;
            ye = ys;
        end else if (kind < 74) begin
            // Corners of the coordinate range.
            xs = $urandom_range(0, 1) ? '1 : '0;
            ys = $urandom_range(0, 1) ? '1 : '0;
            xe = $urandom_range(0, 1) ? '1 : '0;
            ye = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            xs = COORD_BITS'($urandom);
            ys = COORD_BITS'($urandom);
            xe = COORD_BITS'($urandom);
            ye = COORD_BITS'($urandom);
        end
        queue_load(slot, xs, ys, xe, ye);
    endtask

    // Hold until the driver is empty and every predicted result has arrived,
    // then let a trailing load finish.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; only called while idle.
    task automatic write_config(input logic [LIMIT_W-1:0] limit, input int walk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SEGS;
        i_cfg_data <= CFG_DATA_W'(walk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_shadow = limit;
        walk_shadow  = SEGS_W'(walk);
        gen_walk     = (walk > MAX_SEGMENTS) ? MAX_SEGMENTS : walk;
    endtask

    // One random phase: new setting, new shared line, and a full drain halfway
    // through so the sender sits idle until every result is back.
    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int walk,
                             input int count, input bit idle);
        wait_drained();
        write_config(limit, walk);
        idle_on = idle;
        line_ox = $urandom_range(800, 3200);
        line_oy = $urandom_range(800, 3200);
        line_ux = int'($urandom_range(0, 8)) - 4;
        line_uy = int'($urandom_range(0, 8)) - 4;
        if (line_ux == 0 && line_uy == 0)
            line_ux = 3;
        repeat (count / 2) add_random_request();
        wait_drained();
        repeat (count - count / 2) add_random_request();
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length; when idling, random gaps between them
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predict_request(req_bus.payload);
                void'(pending_reqs.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = idle_on ? $urandom_range(1, 8) : 0;
                end
            end
            if (req_bus.valid && !req_bus.ready) begin
                // Hold the request until the block takes it.
            end else if (gap_left > 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_bus.valid   <= 1'b1;
                req_bus.payload <= pending_reqs[0];
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: when idling, stall on a random bit pattern, about one in four
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_phase = 0;
        end else begin
            if (stall_phase == 0)
                stall_pattern = $urandom | $urandom;
            res_bus.ready <= !idle_on || stall_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % 32;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end else if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $error("result for partner %0d arrived with none expected",
                               res_bus.payload.partner);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, res_bus.payload.hit);
                    check_field("partner", want.partner, res_bus.payload.partner);
                    check_field("bridge_from_x", want.bridge_from_x,
                                res_bus.payload.bridge_from_x);
                    check_field("bridge_from_y", want.bridge_from_y,
                                res_bus.payload.bridge_from_y);
                    check_field("bridge_to_x", want.bridge_to_x, res_bus.payload.bridge_to_x);
                    check_field("bridge_to_y", want.bridge_to_y, res_bus.payload.bridge_to_y);
                    check_field("last", want.last, res_bus.payload.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        // Known values on every input from time zero.
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LIMIT;
        i_cfg_data      = '0;
        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        res_bus.ready   = 1'b0;
        idle_on         = 1'b1;
        quiet_cycles    = 0;
        mismatches      = 0;
        gen_loaded      = '0;
        limit_shadow    = LIMIT_RESET;
        walk_shadow     = SEGS_RESET;
        gen_walk        = MAX_SEGMENTS;
        foreach (seg_shadow[k])
            seg_shadow[k] = '0;
        line_ox = 2000;
        line_oy = 2000;
        line_ux = 3;
        line_uy = 1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a short walk of four slots.
        write_config(LIMIT_RESET, 4);
        queue_load(0, 12'd0, 12'd0, 12'd4095, 12'd4095);       // full-range diagonal
        queue_load(1, 12'd4095, 12'd4095, 12'd0, 12'd0);       // same line reversed: ties
        queue_load(2, 12'd100, 12'd100, 12'd100, 12'd100);     // zero-length segment
        queue_load(3, 12'd2000, 12'd0, 12'd2000, 12'd4095);    // vertical line
        queue_query(0);
        queue_query(1);
        queue_query(2);                                        // zero-length reference
        queue_query(3);
        queue_load(1, 12'd2010, 12'd4080, 12'd3000, 12'd100);  // close to the vertical's end
        queue_query(3);
        queue_load(2, 12'd0, 12'd4095, 12'd4095, 12'd4095);    // horizontal along the top
        queue_query(2);
        queue_query(0);
        queue_load(31, 12'd4095, 12'd0, 12'd0, 12'd4095);      // anti-diagonal, unwalked slot
        queue_query(31);

        // Random phases: reset-value limit, never-hit limit, a limit of 2^25 on a
        // single-slot walk, then mid-range settings, with and without idling.
        run_phase(LIMIT_RESET, 32, 90, 1'b1);
        run_phase('0, 32, 40, 1'b0);
        run_phase(LIMIT_W'(33554432), 1, 40, 1'b1);
        run_phase(LIMIT_W'(50), 17, 60, 1'b1);
        run_phase(LIMIT_W'(10000), 32, 60, 1'b0);
        run_phase(LIMIT_RESET, 32, 50, 1'b1);
        wait_drained();

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
